// File: design/kepler_orbit_propagator_defines.svh
// Assertion macros used by the Kepler orbit propagator datapath.
`ifndef KEPLER_ORBIT_PROPAGATOR_DEFINES_SVH
`define KEPLER_ORBIT_PROPAGATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KOP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KOP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define KOP_ASSERT(lbl, clk, rst_n, prop, msg)
`define KOP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: design/kop_pkg.sv
// Types, constants and tables of the Kepler orbit propagator.
package kop_pkg;

  localparam int unsigned ITER_LIMIT_DEF = 30;
  localparam int unsigned ANGLE_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned ITERS_W    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMA   = 3'd0,
    REG_ECC   = 3'd1,
    REG_MM    = 3'd2,
    REG_START = 3'd3,
    REG_TOL   = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] SMA_RST        = 32'd65536;
  localparam logic [15:0] TOL_RST        = 16'd6836;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [15:0] ECC_PI_MIN     = 16'd52429;
  localparam logic [31:0] HALF_TURN      = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
  localparam logic [31:0] DEN_MIN        = 32'h0000_4000;

  localparam int unsigned TAY_TERMS = 6;
  localparam int unsigned DIV_STEPS = 62;

  // Horner divisors of the sine series, highest term first.
  function automatic logic [7:0] tay_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0: d = 8'd156;
      3'd1: d = 8'd110;
      3'd2: d = 8'd72;
      3'd3: d = 8'd42;
      3'd4: d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for each divisor above.
  function automatic logic [31:0] tay_recip(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd0: r = 32'd27531841;
      3'd1: r = 32'd39045157;
      3'd2: r = 32'd59652323;
      3'd3: r = 32'd102261126;
      3'd4: r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_PHASE, OP_INIT, OP_SIN_START, OP_SIN_R, OP_SIN_R2,
    OP_TAY_MUL, OP_TAY_REC, OP_TAY_QD, OP_TAY_REM, OP_TAY_FIX, OP_TAY_NEXT,
    OP_SIN_END, OP_SIN_MAG, OP_EMUL, OP_RES_P, OP_RES_F, OP_DEN, OP_DIV_LOAD,
    OP_DIV_STEP, OP_NEWTON, OP_RAD_MUL, OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic cos_sel;
  } cmd_t;

  typedef struct packed {
    logic fix_needed;
    logic last_term;
    logic f_ok;
    logic iter_max;
    logic div_last;
    logic out_busy;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PHASE, ST_INIT, ST_SIN_START, ST_SIN_R, ST_SIN_R2, ST_TAY_MUL,
    ST_TAY_REC, ST_TAY_QD, ST_TAY_REM, ST_TAY_FIX, ST_SIN_END, ST_SIN_MAG,
    ST_EMUL, ST_RES_P, ST_RES_F, ST_CHECK, ST_DEN, ST_DIV_LOAD, ST_DIV,
    ST_NEWTON, ST_RAD_MUL, ST_FINISH
  } st_e;

  typedef enum logic [1:0] {
    PURP_RES, PURP_NEWTON, PURP_RADIUS
  } purp_e;

endpackage

// File: design/kop_ifs.sv
// Request and result channel interfaces of the Kepler orbit propagator.
interface kop_req_if import kop_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [STEP_W-1:0] time_step;
  modport source(output valid, kind, time_step, input ready);
  modport sink(input valid, kind, time_step, output ready);
endinterface

interface kop_rsp_if import kop_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [31:0]        eccentric_anomaly;
  logic [31:0]        mean_anomaly;
  logic [31:0]        orbit_radius;
  logic [ITERS_W-1:0] iterations_used;
  logic               converged;
  modport source(output valid, eccentric_anomaly, mean_anomaly, orbit_radius,
                 iterations_used, converged, input ready);
  modport sink(input valid, eccentric_anomaly, mean_anomaly, orbit_radius,
               iterations_used, converged, output ready);
endinterface

// File: design/kop_ctrl.sv
// Sequencer that steps the datapath through the Newton solve.
module kop_ctrl import kop_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  st_e   state_q, state_d;
  purp_e purp_q, purp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      purp_q  <= PURP_RES;
    end else begin
      state_q <= state_d;
      purp_q  <= purp_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    purp_d        = purp_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.cos_sel = (purp_q != PURP_RES);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd_o.op = OP_PHASE;
        state_d  = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        purp_d   = PURP_RES;
        state_d  = ST_SIN_START;
      end
      ST_SIN_START: begin
        cmd_o.op = OP_SIN_START;
        state_d  = ST_SIN_R;
      end
      ST_SIN_R: begin
        cmd_o.op = OP_SIN_R;
        state_d  = ST_SIN_R2;
      end
      ST_SIN_R2: begin
        cmd_o.op = OP_SIN_R2;
        state_d  = ST_TAY_MUL;
      end
      ST_TAY_MUL: begin
        cmd_o.op = OP_TAY_MUL;
        state_d  = ST_TAY_REC;
      end
      ST_TAY_REC: begin
        cmd_o.op = OP_TAY_REC;
        state_d  = ST_TAY_QD;
      end
      ST_TAY_QD: begin
        cmd_o.op = OP_TAY_QD;
        state_d  = ST_TAY_REM;
      end
      ST_TAY_REM: begin
        cmd_o.op = OP_TAY_REM;
        state_d  = ST_TAY_FIX;
      end
      ST_TAY_FIX: begin
        if (sts_i.fix_needed) begin
          cmd_o.op = OP_TAY_FIX;
        end else begin
          cmd_o.op = OP_TAY_NEXT;
          state_d  = sts_i.last_term ? ST_SIN_END : ST_TAY_MUL;
        end
      end
      ST_SIN_END: begin
        cmd_o.op = OP_SIN_END;
        state_d  = ST_SIN_MAG;
      end
      ST_SIN_MAG: begin
        cmd_o.op = OP_SIN_MAG;
        state_d  = ST_EMUL;
      end
      ST_EMUL: begin
        cmd_o.op = OP_EMUL;
        state_d  = (purp_q == PURP_RES) ? ST_RES_P : ST_DEN;
      end
      ST_RES_P: begin
        cmd_o.op = OP_RES_P;
        state_d  = ST_RES_F;
      end
      ST_RES_F: begin
        cmd_o.op = OP_RES_F;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        purp_d  = (sts_i.f_ok || sts_i.iter_max) ? PURP_RADIUS : PURP_NEWTON;
        state_d = ST_SIN_START;
      end
      ST_DEN: begin
        cmd_o.op = OP_DEN;
        state_d  = (purp_q == PURP_NEWTON) ? ST_DIV_LOAD : ST_RAD_MUL;
      end
      ST_DIV_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) begin
          state_d = ST_NEWTON;
        end
      end
      ST_NEWTON: begin
        cmd_o.op = OP_NEWTON;
        purp_d   = PURP_RES;
        state_d  = ST_SIN_START;
      end
      ST_RAD_MUL: begin
        cmd_o.op = OP_RAD_MUL;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_PUBLISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/kop_dp.sv
// Datapath: configuration, phase, shared multiplier, sine series, divider.
`include "kepler_orbit_propagator_defines.svh"
module kop_dp import kop_pkg::*; #(
  parameter int unsigned ITER_LIMIT = ITER_LIMIT_DEF,
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  kind_i,
  input  logic [STEP_W-1:0]     time_step_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           out_ecc_anom_o,
  output logic [31:0]           out_mean_anom_o,
  output logic [31:0]           out_radius_o,
  output logic [ITERS_W-1:0]    out_iters_o,
  output logic                  out_conv_o
);

  localparam int unsigned ITER_W = $clog2(ITER_LIMIT + 1);
  localparam int unsigned INC_SH = 48 - ANGLE_BITS;
  localparam int unsigned DIV_W  = $clog2(DIV_STEPS);

  // Configuration registers.
  logic [31:0] sma_q, mm_q, start_q;
  logic [15:0] ecc_q, tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sma_q   <= SMA_RST;
      ecc_q   <= '0;
      mm_q    <= '0;
      start_q <= '0;
      tol_q   <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SMA:   sma_q   <= cfg_data_i[31:0];
        REG_ECC:   ecc_q   <= cfg_data_i[15:0];
        REG_MM:    mm_q    <= cfg_data_i[31:0];
        REG_START: start_q <= cfg_data_i[31:0];
        REG_TOL:   tol_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  logic [ANGLE_BITS-1:0] phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic [63:0]           prod_q, prod_d;
  logic [31:0]           m_q, m_d, e_q, e_d;
  logic                  neg_q, neg_d;
  logic [30:0]           r_q, r_d, t_q, t_d, mag_q, mag_d;
  logic [31:0]           r2_q, r2_d, x_q, x_d, qt_q, qt_d, rem_q, rem_d;
  logic [2:0]            k_q, k_d;
  logic [33:0]           f_q, f_d;
  logic [31:0]           den_q, den_d, drem_q, drem_d;
  logic [61:0]           dq_q, dq_d;
  logic [DIV_W-1:0]      cnt_q, cnt_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [31:0]           oe_q, oe_d, om_q, om_d, orad_q, orad_d;
  logic [ITERS_W-1:0]    oit_q, oit_d;
  logic                  oconv_q, oconv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    prod_q  <= prod_d;
    m_q     <= m_d;
    e_q     <= e_d;
    neg_q   <= neg_d;
    r_q     <= r_d;
    t_q     <= t_d;
    mag_q   <= mag_d;
    r2_q    <= r2_d;
    x_q     <= x_d;
    qt_q    <= qt_d;
    rem_q   <= rem_d;
    k_q     <= k_d;
    f_q     <= f_d;
    den_q   <= den_d;
    drem_q  <= drem_d;
    dq_q    <= dq_d;
    cnt_q   <= cnt_d;
    iter_q  <= iter_d;
    oe_q    <= oe_d;
    om_q    <= om_d;
    orad_q  <= orad_d;
    oit_q   <= oit_d;
    oconv_q <= oconv_d;
  end

  // Derived values.
  logic [ANGLE_BITS+31:0] start_ext, phase_ext;
  logic [ANGLE_BITS-1:0]  start_phase, inc;
  logic [31:0]            m_now, ang, dv, term;
  logic [1:0]             quad;
  logic [30:0]            u;
  logic [7:0]             tdiv;
  logic [33:0]            diff, fabs, tol_pos, tol_neg;
  logic [32:0]            s_full, trial;
  logic                   trial_ge;
  logic [29:0]            ecos;
  logic [ITER_W+ITERS_W-1:0] iter_ext;

  assign start_ext   = {start_q, {ANGLE_BITS{1'b0}}};
  assign start_phase = start_ext[ANGLE_BITS+31:32];
  assign phase_ext   = {phase_q, 32'b0};
  assign m_now       = phase_ext[ANGLE_BITS+31:ANGLE_BITS];
  assign inc         = prod_q[INC_SH +: ANGLE_BITS];

  assign ang  = cmd_i.cos_sel ? (e_q + QUARTER_TURN) : e_q;
  assign quad = ang[31:30];
  assign u    = quad[0] ? (ONE_Q30[30:0] - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
  assign tdiv = tay_div(k_q);

  assign s_full = prod_q[62:30];
  assign dv     = e_q - m_q;
  assign diff   = {{2{dv[31]}}, dv};
  assign term   = prod_q[63:32];
  assign fabs   = f_q[33] ? (34'd0 - f_q) : f_q;
  assign ecos   = prod_q[45:16];

  assign tol_pos = {18'b0, tol_q};
  assign tol_neg = 34'd0 - tol_pos;

  assign trial    = {drem_q, dq_q[61]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign iter_ext = {{ITERS_W{1'b0}}, iter_q};

  // Shared 32x32 multiplier, result registered in prod_q.
  logic [31:0] mul_a, mul_b;
  logic        mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_ACCEPT: begin
        mul_a = mm_q;
        mul_b = {8'b0, time_step_i};
      end
      OP_SIN_START: begin
        mul_a = {1'b0, u};
        mul_b = HALF_PI_Q30;
      end
      OP_SIN_R: begin
        mul_a = {1'b0, prod_q[60:30]};
        mul_b = {1'b0, prod_q[60:30]};
      end
      OP_TAY_MUL: begin
        mul_a = r2_q;
        mul_b = {1'b0, t_q};
      end
      OP_TAY_REC: begin
        mul_a = prod_q[61:30];
        mul_b = tay_recip(k_q);
      end
      OP_TAY_QD: begin
        mul_a = prod_q[63:32];
        mul_b = {24'b0, tdiv};
      end
      OP_SIN_END: begin
        mul_a = {1'b0, r_q};
        mul_b = {1'b0, t_q};
      end
      OP_EMUL: begin
        mul_a = {16'b0, ecc_q};
        mul_b = {1'b0, mag_q};
      end
      OP_RES_P: begin
        mul_a = prod_q[45:14];
        mul_b = INV_TWO_PI_Q32;
      end
      OP_RAD_MUL: begin
        mul_a = sma_q;
        mul_b = den_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    prod_d      = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_q;
    m_d         = m_q;
    e_d         = e_q;
    neg_d       = neg_q;
    r_d         = r_q;
    t_d         = t_q;
    mag_d       = mag_q;
    r2_d        = r2_q;
    x_d         = x_q;
    qt_d        = qt_q;
    rem_d       = rem_q;
    k_d         = k_q;
    f_d         = f_q;
    den_d       = den_q;
    drem_d      = drem_q;
    dq_d        = dq_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    oe_d        = oe_q;
    om_d        = om_q;
    orad_d      = orad_q;
    oit_d       = oit_q;
    oconv_d     = oconv_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (cmd_i.op)
      OP_ACCEPT:    kind_d = kind_i;
      OP_PHASE:     phase_d = kind_q ? start_phase : (phase_q + inc);
      OP_INIT: begin
        m_d    = m_now;
        e_d    = (ecc_q >= ECC_PI_MIN) ? HALF_TURN : m_now;
        iter_d = '0;
      end
      OP_SIN_START: neg_d = quad[1];
      OP_SIN_R:     r_d = prod_q[60:30];
      OP_SIN_R2: begin
        r2_d = prod_q[61:30];
        t_d  = ONE_Q30[30:0];
        k_d  = '0;
      end
      OP_TAY_REC:   x_d = prod_q[61:30];
      OP_TAY_QD:    qt_d = prod_q[63:32];
      OP_TAY_REM:   rem_d = x_q - prod_q[31:0];
      OP_TAY_FIX: begin
        qt_d  = qt_q + 32'd1;
        rem_d = rem_q - {24'b0, tdiv};
      end
      OP_TAY_NEXT: begin
        t_d = ONE_Q30[30:0] - qt_q[30:0];
        k_d = k_q + 3'd1;
      end
      OP_SIN_MAG:   mag_d = (s_full > {1'b0, ONE_Q30}) ? ONE_Q30[30:0] : s_full[30:0];
      OP_RES_F:     f_d = neg_q ? (diff + {2'b0, term}) : (diff - {2'b0, term});
      OP_DEN:       den_d = neg_q ? (ONE_Q30 + {2'b0, ecos}) : (ONE_Q30 - {2'b0, ecos});
      OP_DIV_LOAD: begin
        dq_d   = {fabs[31:0], 30'b0};
        drem_d = '0;
        cnt_d  = '0;
      end
      OP_DIV_STEP: begin
        drem_d = trial_ge ? (trial[31:0] - den_q) : trial[31:0];
        dq_d   = {dq_q[60:0], trial_ge};
        cnt_d  = cnt_q + 1'b1;
      end
      OP_NEWTON: begin
        e_d    = f_q[33] ? (e_q + dq_q[31:0]) : (e_q - dq_q[31:0]);
        iter_d = iter_q + 1'b1;
      end
      OP_PUBLISH: begin
        out_valid_d = 1'b1;
        oe_d        = e_q;
        om_d        = m_q;
        orad_d      = (prod_q[63:62] != 2'b00) ? 32'hFFFF_FFFF : prod_q[61:30];
        oit_d       = iter_ext[ITERS_W-1:0];
        oconv_d     = sts_o.f_ok;
      end
      default: ;
    endcase
  end

  assign sts_o.fix_needed = (rem_q >= {24'b0, tdiv});
  assign sts_o.last_term  = (k_q == 3'(TAY_TERMS - 1));
  assign sts_o.f_ok       = ($signed(f_q) <= $signed(tol_pos)) &&
                            ($signed(f_q) >= $signed(tol_neg));
  assign sts_o.iter_max   = (iter_q >= ITER_W'(ITER_LIMIT));
  assign sts_o.div_last   = (cnt_q == DIV_W'(DIV_STEPS - 1));
  assign sts_o.out_busy   = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign out_ecc_anom_o  = oe_q;
  assign out_mean_anom_o = om_q;
  assign out_radius_o    = orad_q;
  assign out_iters_o     = oit_q;
  assign out_conv_o      = oconv_q;

  `KOP_ASSERT(a_publish_free, clk_i, rst_ni, (cmd_i.op == OP_PUBLISH) |-> !out_valid_q, "result overwritten")
  `KOP_ASSERT_NEXT(a_publish_shows, clk_i, rst_ni, (cmd_i.op == OP_PUBLISH), out_valid_q, "result not shown")
  `KOP_ASSERT(a_div_rem, clk_i, rst_ni, (cmd_i.op == OP_DIV_STEP) |-> (drem_q < den_q), "divider remainder too large")
  `KOP_ASSERT(a_den_min, clk_i, rst_ni, (cmd_i.op == OP_DIV_LOAD) |-> (den_q >= DEN_MIN), "Newton denominator too small")
  `KOP_ASSERT(a_iter_cap, clk_i, rst_ni, (cmd_i.op == OP_NEWTON) |-> (iter_q < ITER_W'(ITER_LIMIT)), "Newton step past limit")

endmodule

// File: design/kepler_orbit_propagator.sv
// Kepler orbit propagator: solves Kepler's equation for each request.
//
// A request on req_i is either a tick (kind 0), which advances the mean
// anomaly phase by mean_motion * time_step, or a restart (kind 1), which
// reloads the phase from start_phase. Each request yields exactly one
// result on rsp_o: the eccentric anomaly, the mean anomaly, the focal
// radius, the Newton step count and a converged flag.
// The block works on one request at a time and runs at most ITERATION_LIMIT
// Newton steps for each request. The time is set by the one shared 32x32
// multiplier that evaluates each sine series term by term and by the
// bit-serial divider of every Newton step.
// Results sit in an output register, so the next request is taken while the
// previous result waits; a stalled receiver only holds the block at the end
// of the following request. Reset loads the default configuration, clears
// the phase and empties the output register. Configuration is written on
// cfg_we_i with the register index on cfg_idx_i; unknown indexes are ignored.
module kepler_orbit_propagator import kop_pkg::*; #(
  parameter int unsigned ITERATION_LIMIT = ITER_LIMIT_DEF,
  parameter int unsigned ANGLE_BITS      = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  kop_req_if.sink               req_i,
  kop_rsp_if.source             rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The sequencer owns all timing; the datapath only executes commands.
  kop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  assign req_i.ready = in_ready;

  kop_dp #(
    .ITER_LIMIT (ITERATION_LIMIT),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (req_i.kind),
    .time_step_i     (req_i.time_step),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_ecc_anom_o  (rsp_o.eccentric_anomaly),
    .out_mean_anom_o (rsp_o.mean_anomaly),
    .out_radius_o    (rsp_o.orbit_radius),
    .out_iters_o     (rsp_o.iterations_used),
    .out_conv_o      (rsp_o.converged)
  );

endmodule
